FILE: sv/postfix_stack_evaluator_assert.svh
// Assertion macros used by the postfix stack evaluator top level.
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define PSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pse_pkg.sv
// Types, codes and helpers shared by the postfix stack evaluator.
package pse_pkg;

  localparam int DATA_W = 32;

  typedef logic [DATA_W-1:0] word_t;

  // Status codes reported with each result.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_DIVZERO   = 2'd3;

  // Operator characters.
  localparam logic [7:0] SYM_ADD = 8'h2B;
  localparam logic [7:0] SYM_SUB = 8'h2D;
  localparam logic [7:0] SYM_MUL = 8'h2A;
  localparam logic [7:0] SYM_DIV = 8'h2F;
  localparam logic [7:0] SYM_XOR = 8'h5E;
  localparam logic [7:0] SYM_MOD = 8'h25;

  // Offset subtracted from any other character before it is pushed.
  localparam word_t DIGIT_BASE = 32'd48;

  localparam logic [7:0] LIMIT_RESET = 8'd100;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_EMIT
  } state_t;

  function automatic logic is_operator(input logic [7:0] sym);
    logic hit;
    case (sym) inside
      SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV, SYM_XOR, SYM_MOD: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

FILE: sv/pse_sym_if.sv
// Channel carrying one expression character per transfer.
interface pse_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink (input valid, input symbol, input last, output ready);
endinterface

FILE: sv/pse_res_if.sv
// Channel carrying one evaluation result per transfer.
interface pse_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] top_value;
  logic [7:0]         stack_depth;
  logic [1:0]         status;
  logic               expression_done;

  modport source (output valid, output top_value, output stack_depth, output status,
                  output expression_done, input ready);
  modport sink (input valid, input top_value, input stack_depth, input status,
                input expression_done, output ready);
endinterface

FILE: sv/pse_cfg_if.sv
// Write channel for the stack limit register.
interface pse_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/postfix_stack_evaluator.sv
// Top level of the postfix stack evaluator: sequencer, stack memory and result register.
//
//   Channel  Role  Payload                                            Transfer when
//   cfg      sink  data (stack limit)                                 valid && ready
//   chars    sink  symbol, last                                       valid && ready
//   results  src   top_value, stack_depth, status, expression_done    valid && ready
//
// A push, or any character after an error, goes straight to emit; + - * ^ first pass
// through a read state for the stack memory read of the second operand; / and % pass
// through that read state, the divider's 32 single-bit steps, its sign fix and done.
// The result register lets the next character enter while a result waits; a result
// stalled on the output holds the sequencer in its emit state.
// Reset is synchronous: stack pointer, status, limit (100) and all valid flags clear.
`include "postfix_stack_evaluator_assert.svh"

module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = 128
) (
  input logic clk,
  input logic rst,
  pse_cfg_if.sink    cfg,
  pse_sym_if.sink    chars,
  pse_res_if.source  results
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int LW     = (SP_W > 8) ? SP_W : 8;

  pse_pkg::state_t state, state_next;

  logic [7:0]      stack_limit;
  logic [SP_W-1:0] sp, sp_next;
  logic [1:0]      err, err_next;
  pse_pkg::word_t  top, top_next;
  logic [7:0]      sym_q;
  logic            last_q;

  pse_pkg::word_t  mem [STACK_DEPTH];
  pse_pkg::word_t  rd_data;
  logic            mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  pse_pkg::word_t  mem_wdata;

  logic            res_valid;
  logic signed [31:0] res_top;
  logic [7:0]      res_depth;
  logic [1:0]      res_status;
  logic            res_done;

  logic            div_start;
  logic            div_done;
  pse_pkg::word_t  div_q;
  pse_pkg::word_t  div_r;

  logic            accept;
  logic            out_free;
  logic            in_is_op;
  logic [SP_W-1:0] sp_m2;
  logic [LW-1:0]   sp_ext;
  logic [LW-1:0]   lim_ext;
  logic [LW-1:0]   lim_eff;
  logic            push_ok;
  logic            under;
  pse_pkg::word_t  push_val;
  logic            op_divlike;
  logic            div_zero;
  pse_pkg::word_t  alu_r;

  assign cfg.ready   = 1'b1;
  assign chars.ready = (state == pse_pkg::S_IDLE);
  assign accept      = chars.valid && chars.ready;
  assign out_free    = !res_valid || results.ready;

  assign results.valid           = res_valid;
  assign results.top_value       = res_top;
  assign results.stack_depth     = res_depth;
  assign results.status          = res_status;
  assign results.expression_done = res_done;

  assign in_is_op = pse_pkg::is_operator(chars.symbol);
  assign sp_m2    = sp - SP_W'(2);
  assign sp_ext   = LW'(sp);
  assign lim_ext  = LW'(stack_limit);
  assign lim_eff  = (lim_ext > LW'(STACK_DEPTH)) ? LW'(STACK_DEPTH) : lim_ext;
  assign push_ok  = sp_ext < lim_eff;
  assign under    = sp < SP_W'(2);
  assign push_val = pse_pkg::word_t'(chars.symbol) - pse_pkg::DIGIT_BASE;

  assign op_divlike = (sym_q == pse_pkg::SYM_DIV) || (sym_q == pse_pkg::SYM_MOD);
  assign div_zero   = (top == '0);

  // Operand b is the cached top, operand c comes from the memory read.
  always_comb begin
    case (sym_q)
      pse_pkg::SYM_ADD: alu_r = rd_data + top;
      pse_pkg::SYM_SUB: alu_r = rd_data - top;
      pse_pkg::SYM_MUL: alu_r = rd_data * top;
      default:          alu_r = rd_data ^ top;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pse_pkg::S_IDLE: begin
        if (accept) begin
          if (err == pse_pkg::ST_OK && in_is_op && !under) begin
            state_next = pse_pkg::S_READ;
          end else begin
            state_next = pse_pkg::S_EMIT;
          end
        end
      end
      pse_pkg::S_READ: begin
        if (op_divlike && !div_zero) begin
          state_next = pse_pkg::S_DIV;
        end else begin
          state_next = pse_pkg::S_EMIT;
        end
      end
      pse_pkg::S_DIV: begin
        if (div_done) begin
          state_next = pse_pkg::S_EMIT;
        end
      end
      pse_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = pse_pkg::S_IDLE;
        end
      end
      default: state_next = pse_pkg::S_IDLE;
    endcase
  end

  // Datapath controls.
  always_comb begin
    sp_next   = sp;
    err_next  = err;
    top_next  = top;
    mem_we    = 1'b0;
    mem_waddr = sp[ADDR_W-1:0];
    mem_wdata = push_val;
    div_start = 1'b0;
    unique case (state)
      pse_pkg::S_IDLE: begin
        if (accept && err == pse_pkg::ST_OK) begin
          if (in_is_op) begin
            if (under) begin
              err_next = pse_pkg::ST_UNDERFLOW;
            end
          end else if (push_ok) begin
            mem_we   = 1'b1;
            top_next = push_val;
            sp_next  = sp + SP_W'(1);
          end else begin
            err_next = pse_pkg::ST_OVERFLOW;
          end
        end
      end
      pse_pkg::S_READ: begin
        if (op_divlike) begin
          if (div_zero) begin
            err_next = pse_pkg::ST_DIVZERO;
          end else begin
            div_start = 1'b1;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = sp_m2[ADDR_W-1:0];
          mem_wdata = alu_r;
          top_next  = alu_r;
          sp_next   = sp - SP_W'(1);
        end
      end
      pse_pkg::S_DIV: begin
        if (div_done) begin
          mem_we    = 1'b1;
          mem_waddr = sp_m2[ADDR_W-1:0];
          mem_wdata = (sym_q == pse_pkg::SYM_DIV) ? div_q : div_r;
          top_next  = mem_wdata;
          sp_next   = sp - SP_W'(1);
        end
      end
      pse_pkg::S_EMIT: begin
        if (out_free && last_q) begin
          sp_next  = '0;
          err_next = pse_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pse_pkg::S_IDLE;
      sp          <= '0;
      err         <= pse_pkg::ST_OK;
      stack_limit <= pse_pkg::LIMIT_RESET;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      sp    <= sp_next;
      err   <= err_next;
      if (cfg.valid && cfg.ready) begin
        stack_limit <= cfg.data;
      end
      if (state == pse_pkg::S_EMIT && out_free) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
    if (accept) begin
      sym_q  <= chars.symbol;
      last_q <= chars.last;
    end
    if (state == pse_pkg::S_EMIT && out_free) begin
      res_top    <= (sp == '0) ? 32'sd0 : signed'(top);
      res_depth  <= sp_ext[7:0];
      res_status <= err;
      res_done   <= last_q;
    end
  end

  // Stack memory. The read address follows sp - 2 and is consumed in the next cycle;
  // every write lands before a consumed read of the same entry is issued.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[sp_m2[ADDR_W-1:0]];
  end

  pse_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rd_data),
    .divisor   (top),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  `PSE_ASSERT_NOW(a_empty_top_zero, results.valid && results.stack_depth == 8'd0, results.top_value == 32'sd0, "result reports a nonzero top on an empty stack")
  `PSE_ASSERT_NOW(a_div_done_in_div, div_done, state == pse_pkg::S_DIV, "divider finished outside the divide state")
  `PSE_ASSERT_NEXT(a_accept_leaves_idle, chars.valid && chars.ready, state != pse_pkg::S_IDLE, "sequencer stayed idle after a character transfer")

endmodule

FILE: sv/pse_divider.sv
// Iterative signed divider: one quotient bit per cycle, then a sign fix step.
module pse_divider (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  pse_pkg::word_t dividend,
  input  pse_pkg::word_t divisor,
  output logic           done,
  output pse_pkg::word_t quotient,
  output pse_pkg::word_t remainder
);

  localparam int W     = pse_pkg::DATA_W;
  localparam int CNT_W = $clog2(W);

  logic             run;
  logic             fix;
  logic [CNT_W-1:0] count;
  pse_pkg::word_t   rem;
  pse_pkg::word_t   quo;
  pse_pkg::word_t   dvs;
  logic             neg_q;
  logic             neg_r;

  logic [W:0]       shifted;
  logic [W:0]       diff;

  // The partial remainder stays below the divisor magnitude, so W bits hold it.
  assign shifted = {rem, quo[W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && count == CNT_W'(W - 1)) begin
        run <= 1'b0;
        fix <= 1'b1;
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // Magnitudes are taken as unsigned, so the most negative value works too.
      quo   <= dividend[W-1] ? (~dividend + pse_pkg::word_t'(1)) : dividend;
      dvs   <= divisor[W-1] ? (~divisor + pse_pkg::word_t'(1)) : divisor;
      rem   <= '0;
      count <= '0;
      neg_q <= dividend[W-1] ^ divisor[W-1];
      neg_r <= dividend[W-1];
    end else if (run) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fix) begin
      quotient  <= neg_q ? (~quo + pse_pkg::word_t'(1)) : quo;
      remainder <= neg_r ? (~rem + pse_pkg::word_t'(1)) : rem;
    end
  end

endmodule
